// ===== design/mpa_pkg.sv =====
package mpa_pkg;

    // Fixed field widths
    localparam int KIND_W     = 2;
    localparam int ROW_W      = 6;
    localparam int COL_W      = 6;
    localparam int PIX_W      = 8;
    localparam int IDX_W      = 11;
    localparam int VALUE_W    = 24;
    localparam int COUNT_W    = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // Configuration register widths
    localparam int P_W   = 4;
    localparam int Q_W   = 5;
    localparam int DIM_W = 7;

    // Internal arithmetic: signed bin index and unclamped bin count
    localparam int CALC_W = 14;
    localparam int CNT_W  = 13;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR = 2'd0,
        KIND_PIXEL = 2'd1,
        KIND_READ  = 2'd2
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ANGLE_P  = 2'd0,
        CFG_ANGLE_Q  = 2'd1,
        CFG_NUM_ROWS = 2'd2,
        CFG_NUM_COLS = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CALC,
        ST_CHECK,
        ST_CLEAR,
        ST_UPDATE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_item;
        logic calc_en;
        logic check_en;
        logic clr_step;
        logic upd_en;
        logic out_load;
    } mpa_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  go;
        logic  clr_last;
        logic  out_free;
    } mpa_sts_t;

endpackage

// ===== design/mpa_if.sv =====
interface mpa_item_if import mpa_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [KIND_W-1:0] kind;
    logic [ROW_W-1:0]  pixel_row;
    logic [COL_W-1:0]  pixel_col;
    logic [PIX_W-1:0]  pixel_value;
    logic [IDX_W-1:0]  bin_index;

    modport source (output valid, kind, pixel_row, pixel_col, pixel_value, bin_index,
                    input ready);
    modport sink (input valid, kind, pixel_row, pixel_col, pixel_value, bin_index,
                  output ready);
endinterface

interface mpa_result_if import mpa_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] bin_value;
    logic [COUNT_W-1:0] bin_count;
    logic               status;

    modport source (output valid, bin_value, bin_count, status, input ready);
    modport sink (input valid, bin_value, bin_count, status, output ready);
endinterface

interface mpa_cfg_if import mpa_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== design/mpa_ram.sv =====
module mpa_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rd_data_reg;

endmodule

// ===== design/mpa_datapath.sv =====
module mpa_datapath import mpa_pkg::*; #(
    parameter int MAX_DIM    = 64,
    parameter int MAX_SLOPE  = 15,
    parameter int BIN_DEPTH  = 2048,
    parameter int PIXEL_BITS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mpa_cmd_t              cmd,
    output mpa_sts_t              sts,
    // item payload
    input  logic [KIND_W-1:0]     item_kind,
    input  logic [ROW_W-1:0]      item_row,
    input  logic [COL_W-1:0]      item_col,
    input  logic [PIX_W-1:0]      item_value,
    input  logic [IDX_W-1:0]      item_index,
    // configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // result register
    input  logic                  res_ready,
    output logic                  res_valid,
    output logic [VALUE_W-1:0]    res_value,
    output logic [COUNT_W-1:0]    res_count,
    output logic                  res_status
);

    localparam int ADDR_W   = $clog2(BIN_DEPTH);
    localparam int PIX_MASK = (1 << PIXEL_BITS) - 1;

    // configuration
    logic [P_W-1:0]   angle_p_reg;
    logic [Q_W-1:0]   angle_q_reg;
    logic [DIM_W-1:0] num_rows_reg;
    logic [DIM_W-1:0] num_cols_reg;

    // captured item
    kind_t            kind_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic [PIX_W-1:0] pix_reg;
    logic [IDX_W-1:0] idx_reg;

    // products
    logic signed [CALC_W-1:0] qc_reg;
    logic [CALC_W-1:0]        pr_reg;
    logic [CALC_W-1:0]        pr1_reg;
    logic [CALC_W-1:0]        qa_reg;
    logic                     neg_reg;
    logic                     oob_reg;

    // check results
    logic [CNT_W-1:0]  count_reg;
    logic              status_reg;
    logic [ADDR_W-1:0] bin_addr_reg;
    logic [VALUE_W-1:0] value_reg;

    // clearing sweep
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [ADDR_W-1:0] clr_cnt_next;

    // output register
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [VALUE_W-1:0] out_value_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_status_reg;

    logic [DIM_W-1:0]       rows_c;
    logic [DIM_W-1:0]       cols_c;
    logic [P_W-1:0]         p_c;
    logic signed [Q_W-1:0]  q_c;
    logic [Q_W-1:0]         q_abs;
    logic signed [CALC_W-1:0] bin_calc;
    logic [CALC_W-1:0]      count_sum;
    logic [CNT_W-1:0]       count_calc;
    logic                   bin_ok;
    logic                   idx_ok;
    logic                   go;
    logic [ADDR_W-1:0]      raddr;
    logic                   ram_re;
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [VALUE_W-1:0]     ram_wdata;
    logic [VALUE_W-1:0]     ram_rdata;
    logic [VALUE_W:0]       acc_sum;
    logic [PIX_W-1:0]       pix_eff;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (int'(v) > MAX_DIM)
        begin
            r = DIM_W'(MAX_DIM);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_p_reg  <= P_W'(1);
            angle_q_reg  <= '0;
            num_rows_reg <= DIM_W'(64);
            num_cols_reg <= DIM_W'(64);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_ANGLE_P:  angle_p_reg  <= cfg_data[P_W-1:0];
                CFG_ANGLE_Q:  angle_q_reg  <= cfg_data[Q_W-1:0];
                CFG_NUM_ROWS: num_rows_reg <= cfg_data[DIM_W-1:0];
                CFG_NUM_COLS: num_cols_reg <= cfg_data[DIM_W-1:0];
                default:      ;
            endcase
        end
    end

    // clamped angle and size
    always_comb
    begin
        rows_c = clamp_dim(num_rows_reg);
        cols_c = clamp_dim(num_cols_reg);
        p_c    = (int'(angle_p_reg) > MAX_SLOPE) ? P_W'(MAX_SLOPE) : angle_p_reg;
        q_c    = $signed(angle_q_reg);
        if (int'(q_c) > MAX_SLOPE)
        begin
            q_c = Q_W'(MAX_SLOPE);
        end
        else if (int'(q_c) < -MAX_SLOPE)
        begin
            q_c = Q_W'(-MAX_SLOPE);
        end
        q_abs = q_c[Q_W-1] ? Q_W'(-q_c) : Q_W'(q_c);
    end

    // bin index and count from the registered products
    always_comb
    begin
        if (neg_reg)
        begin
            bin_calc = $signed(pr_reg) - qc_reg;
        end
        else
        begin
            bin_calc = qc_reg - $signed(pr_reg) + $signed(pr1_reg);
        end
        count_sum  = CALC_W'(1) + pr1_reg + qa_reg;
        count_calc = count_sum[CNT_W-1:0];
        bin_ok = !oob_reg && !bin_calc[CALC_W-1]
                 && (bin_calc[CNT_W-1:0] < count_calc)
                 && (int'(bin_calc[CNT_W-1:0]) < BIN_DEPTH);
        idx_ok = (CNT_W'(idx_reg) < count_calc) && (int'(idx_reg) < BIN_DEPTH);
        case (kind_reg)
            KIND_PIXEL:
            begin
                go    = bin_ok;
                raddr = ADDR_W'(bin_calc[CNT_W-1:0]);
            end
            KIND_READ:
            begin
                go    = idx_ok;
                raddr = ADDR_W'(idx_reg);
            end
            default:
            begin
                go    = 1'b0;
                raddr = ADDR_W'(idx_reg);
            end
        endcase
        ram_re = cmd.check_en && go;
    end

    // item capture, products and check registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            kind_reg <= kind_t'(item_kind);
            row_reg  <= item_row;
            col_reg  <= item_col;
            pix_reg  <= item_value;
            idx_reg  <= item_index;
        end
        if (cmd.calc_en)
        begin
            qc_reg  <= CALC_W'(q_c) * $signed(CALC_W'(col_reg));
            pr_reg  <= CALC_W'(p_c) * CALC_W'(row_reg);
            pr1_reg <= CALC_W'(p_c) * CALC_W'(rows_c - DIM_W'(1));
            qa_reg  <= CALC_W'(q_abs) * CALC_W'(cols_c - DIM_W'(1));
            neg_reg <= (p_c != '0) && q_c[Q_W-1];
            oob_reg <= (DIM_W'(row_reg) >= rows_c) || (DIM_W'(col_reg) >= cols_c);
        end
        if (cmd.check_en)
        begin
            count_reg    <= count_calc;
            bin_addr_reg <= raddr;
            value_reg    <= '0;
            status_reg   <= ((kind_reg == KIND_PIXEL) || (kind_reg == KIND_READ)) && !go;
        end
        if (cmd.upd_en && (kind_reg == KIND_READ))
        begin
            value_reg <= ram_rdata;
        end
    end

    // saturating accumulate and write port selection
    always_comb
    begin
        pix_eff = pix_reg & PIX_W'(PIX_MASK);
        acc_sum = {1'b0, ram_rdata} + (VALUE_W + 1)'(pix_eff);
        if (cmd.clr_step)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = cmd.upd_en && (kind_reg == KIND_PIXEL);
            ram_waddr = bin_addr_reg;
            ram_wdata = acc_sum[VALUE_W] ? {VALUE_W{1'b1}} : acc_sum[VALUE_W-1:0];
        end
    end

    // clearing sweep counter wraps to zero after the last entry
    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        if (cmd.clr_step)
        begin
            clr_cnt_next = sts.clr_last ? '0 : clr_cnt_reg + ADDR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    mpa_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (BIN_DEPTH)
    ) u_bins (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // output register
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_value_reg  <= value_reg;
            out_count_reg  <= count_reg[COUNT_W-1:0];
            out_status_reg <= status_reg;
        end
    end

    assign sts.kind     = kind_reg;
    assign sts.go       = go;
    assign sts.clr_last = (int'(clr_cnt_reg) == BIN_DEPTH - 1);
    assign sts.out_free = !out_valid_reg || res_ready;

    assign res_valid  = out_valid_reg;
    assign res_value  = out_value_reg;
    assign res_count  = out_count_reg;
    assign res_status = out_status_reg;

endmodule

// ===== design/mpa_ctrl.sv =====
module mpa_ctrl import mpa_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    output mpa_cmd_t cmd,
    input  mpa_sts_t sts
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                item_ready    = 1'b1;
                cmd.load_item = item_valid;
                if (item_valid)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                cmd.calc_en = 1'b1;
                state_next  = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.check_en = 1'b1;
                if (sts.kind == KIND_CLEAR)
                begin
                    state_next = ST_CLEAR;
                end
                else if (sts.go)
                begin
                    state_next = ST_UPDATE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_UPDATE:
            begin
                cmd.upd_en = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

endmodule

// ===== design/mojette_projection_accumulator_unit.sv =====
// Channel  Dir  Payload                                                Handshake
// item     in   kind, pixel_row, pixel_col, pixel_value, bin_index    valid/ready
// result   out  bin_value, bin_count, status                           valid/ready
// cfg      in   index (0 angle_p, 1 angle_q, 2 num_rows, 3 num_cols),  valid/ready
//               data
//
// One item at a time: a pixel or read item passes through capture, multiply, bin check and
// store read, update and output load before the next accept; a kind 3 item or one that
// fails the range check skips the update; a clear item replaces the update with the
// one-entry-per-cycle sweep of the bin store. After reset the block clears the store with
// item.ready low; cfg is always ready. A stalled result holds the block only when the
// next result is due while the previous beat still waits.
module mojette_projection_accumulator_unit import mpa_pkg::*; #(
    parameter int MAX_DIM    = 64,
    parameter int MAX_SLOPE  = 15,
    parameter int BIN_DEPTH  = 2048,
    parameter int PIXEL_BITS = 8
) (
    input logic        clk,
    input logic        rst_n,
    mpa_item_if.sink   item,
    mpa_result_if.source result,
    mpa_cfg_if.sink    cfg
);

    mpa_cmd_t cmd;
    mpa_sts_t sts;
    logic     item_ready;

    // configuration beats are taken at any time
    assign cfg.ready  = 1'b1;
    assign item.ready = item_ready;

    // sequence the item flow and the clearing sweeps
    mpa_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item_ready),
        .cmd        (cmd),
        .sts        (sts)
    );

    // bin arithmetic, bin store and result register
    mpa_datapath #(
        .MAX_DIM    (MAX_DIM),
        .MAX_SLOPE  (MAX_SLOPE),
        .BIN_DEPTH  (BIN_DEPTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .item_kind  (item.kind),
        .item_row   (item.pixel_row),
        .item_col   (item.pixel_col),
        .item_value (item.pixel_value),
        .item_index (item.bin_index),
        .cfg_we     (cfg.valid),
        .cfg_index  (cfg.index),
        .cfg_data   (cfg.data),
        .res_ready  (result.ready),
        .res_valid  (result.valid),
        .res_value  (result.bin_value),
        .res_count  (result.bin_count),
        .res_status (result.status)
    );

endmodule

// ===== sim/tb_mojette_projection_accumulator_unit.sv =====
module tb_mojette_projection_accumulator_unit;
    import mpa_pkg::*;

    // Block parameters, kept at the defaults of the block
    localparam int MAX_DIM    = 64;
    localparam int MAX_SLOPE  = 15;
    localparam int BIN_DEPTH  = 2048;
    localparam int PIXEL_BITS = 8;

    localparam logic [VALUE_W-1:0] BIN_FULL   = {VALUE_W{1'b1}};
    localparam logic [KIND_W-1:0]  KIND_SPARE = 2'd3;
    localparam logic               STATUS_OK    = 1'b0;
    localparam logic               STATUS_RANGE = 1'b1;

    localparam int     RANDOM_ITEMS   = 1525;
    localparam int     LONG_HOLD      = 300;
    localparam int     SETTLE_CYCLES  = 16;
    localparam int     REPORT_MAX     = 10;
    localparam int     DIR_N          = 37;
    localparam longint CYCLE_LIMIT    = 3000000;

    // One input beat of the item channel
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [PIX_W-1:0]  pix;
        logic [IDX_W-1:0]  idx;
    } pix_item_t;

    // One output beat of the result channel
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] count;
        logic               status;
    } bin_result_t;

    // One line of the directed table: a register write or an item, and for some
    // items a result typed in by hand
    typedef struct packed {
        logic                  is_cfg;
        cfg_reg_t              cfg_sel;
        logic [CFG_DATA_W-1:0] cfg_data;
        pix_item_t             beat;
        logic                  pinned;
        bin_result_t           pin;
    } dir_row_t;

    // Effective projection geometry after clamping of the registers
    typedef struct {
        int rows;
        int cols;
        int p;
        int q;
        int count;
    } geometry_t;

    logic   clk;
    logic   rst_n;
    longint cycle_count = 0;
    int     mismatch_count = 0;
    logic   quiet_phase;
    logic   hold_req;

    // Shadow copy of the configuration registers and of the bin store
    logic [P_W-1:0]        shadow_p;
    logic signed [Q_W-1:0] shadow_q;
    logic [DIM_W-1:0]      shadow_rows;
    logic [DIM_W-1:0]      shadow_cols;
    logic [VALUE_W-1:0]    bin_mirror [BIN_DEPTH];

    // Bins that took a pixel lately; reads aim at them so that sums show up
    int          hot_bins [$];
    // Results still owed by the block, oldest first
    bin_result_t bin_reports_due [$];

    mpa_item_if   item_ch ();
    mpa_result_if result_ch ();
    mpa_cfg_if    cfg_ch ();

    mojette_projection_accumulator_unit #(
        .MAX_DIM    (MAX_DIM),
        .MAX_SLOPE  (MAX_SLOPE),
        .BIN_DEPTH  (BIN_DEPTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Stop a run that hangs: a missing result or a stuck ready ends up here
    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("mojette_projection_accumulator_unit: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic int clamp_dim(input logic [DIM_W-1:0] v);
        if (v < 1)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return int'(v);
    endfunction

    // Clamp the slopes and sizes, and derive the number of bins
    function automatic geometry_t current_geometry();
        geometry_t g;
        g.rows = clamp_dim(shadow_rows);
        g.cols = clamp_dim(shadow_cols);
        g.p    = (int'(shadow_p) > MAX_SLOPE) ? MAX_SLOPE : int'(shadow_p);
        g.q    = shadow_q;
        if (g.q > MAX_SLOPE)
            g.q = MAX_SLOPE;
        if (g.q < -MAX_SLOPE)
            g.q = -MAX_SLOPE;
        g.count = 1 + (g.rows - 1) * g.p + (g.cols - 1) * ((g.q < 0) ? -g.q : g.q);
        return g;
    endfunction

    // Apply one accepted beat to the shadow bin store and return the result it owes
    function automatic bin_result_t project_beat(input pix_item_t it);
        geometry_t          g;
        bin_result_t        r;
        int                 b;
        logic [VALUE_W:0]   sum;
        g        = current_geometry();
        r.value  = '0;
        r.count  = COUNT_W'(g.count);
        r.status = STATUS_OK;
        case (it.kind)
            KIND_CLEAR:
            begin
                foreach (bin_mirror[i])
                    bin_mirror[i] = '0;
                hot_bins.delete();
            end
            KIND_PIXEL:
            begin
                if (int'(it.row) >= g.rows || int'(it.col) >= g.cols)
                begin
                    r.status = STATUS_RANGE;
                end
                else
                begin
                    // Same-sign slopes shift the bins so that the lowest lands on zero
                    if (g.p * g.q >= 0)
                        b = g.q * int'(it.col) - g.p * int'(it.row) + g.p * (g.rows - 1);
                    else
                        b = g.p * int'(it.row) - g.q * int'(it.col);
                    if (b < 0 || b >= g.count || b >= BIN_DEPTH)
                    begin
                        r.status = STATUS_RANGE;
                    end
                    else
                    begin
                        sum = bin_mirror[b] + it.pix;
                        bin_mirror[b] = (sum > BIN_FULL) ? BIN_FULL : sum[VALUE_W-1:0];
                        hot_bins.push_back(b);
                        if (hot_bins.size() > 64)
                            void'(hot_bins.pop_front());
                    end
                end
            end
            KIND_READ:
            begin
                if (int'(it.idx) >= g.count || int'(it.idx) >= BIN_DEPTH)
                    r.status = STATUS_RANGE;
                else
                    r.value = bin_mirror[it.idx];
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Rows of the directed table
    // ------------------------------------------------------------------

    function automatic dir_row_t pixel_beat(input int r, input int c, input int v);
        dir_row_t d;
        d           = '0;
        d.beat.kind = KIND_PIXEL;
        d.beat.row  = ROW_W'(r);
        d.beat.col  = COL_W'(c);
        d.beat.pix  = PIX_W'(v);
        return d;
    endfunction

    function automatic dir_row_t read_beat(input int idx);
        dir_row_t d;
        d           = '0;
        d.beat.kind = KIND_READ;
        d.beat.idx  = IDX_W'(idx);
        return d;
    endfunction

    // Clear or unused kind, with every other field at all ones
    function automatic dir_row_t bare_beat(input logic [KIND_W-1:0] kind);
        dir_row_t d;
        d           = '0;
        d.beat      = '1;
        d.beat.kind = kind;
        return d;
    endfunction

    function automatic dir_row_t reg_write(input cfg_reg_t sel, input int data);
        dir_row_t d;
        d          = '0;
        d.is_cfg   = 1'b1;
        d.cfg_sel  = sel;
        d.cfg_data = CFG_DATA_W'(data);
        return d;
    endfunction

    function automatic dir_row_t pinned_to(input dir_row_t d, input int value,
                                           input int count, input logic status);
        dir_row_t o;
        o            = d;
        o.pinned     = 1'b1;
        o.pin.value  = VALUE_W'(value);
        o.pin.count  = COUNT_W'(count);
        o.pin.status = status;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Random stimulus
    // ------------------------------------------------------------------

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [DIM_W-1:0] random_dim();
        case ($urandom_range(0, 9))
            0:       return DIM_W'(1);
            1:       return DIM_W'(MAX_DIM);
            2:       return DIM_W'($urandom_range(0, 127));
            3, 4, 5: return DIM_W'($urandom_range(1, 8));
            default: return DIM_W'($urandom_range(1, MAX_DIM));
        endcase
    endfunction

    // Mostly pixels inside the image and reads of live bins; the rest is noise
    function automatic pix_item_t random_beat();
        pix_item_t it;
        geometry_t g;
        int        pick;
        g       = current_geometry();
        it.row  = ROW_W'($urandom_range(0, 63));
        it.col  = COL_W'($urandom_range(0, 63));
        it.pix  = PIX_W'($urandom_range(0, 255));
        it.idx  = IDX_W'($urandom_range(0, 2047));
        pick    = $urandom_range(0, 99);
        if (pick < 3)
        begin
            it.kind = KIND_CLEAR;
        end
        else if (pick < 6)
        begin
            it.kind = KIND_SPARE;
        end
        else if (pick < 62)
        begin
            it.kind = KIND_PIXEL;
            if ($urandom_range(0, 9) != 0)
            begin
                it.row = ROW_W'($urandom_range(0, g.rows - 1));
                it.col = COL_W'($urandom_range(0, g.cols - 1));
            end
            if ($urandom_range(0, 9) == 0)
                it.pix = ($urandom_range(0, 1) != 0) ? '1 : '0;
        end
        else
        begin
            it.kind = KIND_READ;
            pick    = $urandom_range(0, 99);
            if (pick < 50 && hot_bins.size() != 0)
                it.idx = IDX_W'(hot_bins[$urandom_range(0, hot_bins.size() - 1)]);
            else if (pick < 85)
                it.idx = IDX_W'($urandom_range(0, g.count - 1));
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------

    // Offer one beat from a falling edge, hold it until accepted, then log what it owes
    task automatic send_beat(input pix_item_t it, input logic pinned, input bin_result_t pin);
        bin_result_t want;
        @(negedge clk);
        if (!quiet_phase && $urandom_range(0, 99) < 25)
        begin
            item_ch.valid <= 1'b0;
            repeat (pick_gap()) @(negedge clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.kind        <= it.kind;
        item_ch.pixel_row   <= it.row;
        item_ch.pixel_col   <= it.col;
        item_ch.pixel_value <= it.pix;
        item_ch.bin_index   <= it.idx;
        do
            @(posedge clk);
        while (!item_ch.ready);
        want = project_beat(it);
        bin_reports_due.push_back(pinned ? pin : want);
    endtask

    // Drop valid and wait until every owed result is back and the block has settled
    task automatic wait_idle();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (bin_reports_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= sel;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (sel)
            CFG_ANGLE_P:  shadow_p    = data[P_W-1:0];
            CFG_ANGLE_Q:  shadow_q    = data[Q_W-1:0];
            CFG_NUM_ROWS: shadow_rows = data[DIM_W-1:0];
            CFG_NUM_COLS: shadow_cols = data[DIM_W-1:0];
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Write all four registers, leaning toward the extremes and the clamped codes
    task automatic random_setup();
        logic [CFG_DATA_W-1:0] d;
        case ($urandom_range(0, 9))
            0:       d = 7'd0;
            1:       d = 7'd15;
            2:       d = CFG_DATA_W'($urandom_range(0, 127));
            default: d = CFG_DATA_W'($urandom_range(0, 15));
        endcase
        write_reg(CFG_ANGLE_P, d);
        // 15 and 17 are the slope extremes, 16 is the one that needs clamping
        case ($urandom_range(0, 11))
            0:       d = 7'd15;
            1:       d = 7'd17;
            2:       d = 7'd16;
            3:       d = 7'd0;
            4:       d = CFG_DATA_W'($urandom_range(0, 127));
            default: d = CFG_DATA_W'($urandom_range(0, 31));
        endcase
        write_reg(CFG_ANGLE_Q, d);
        write_reg(CFG_NUM_ROWS, random_dim());
        write_reg(CFG_NUM_COLS, random_dim());
    endtask

    task automatic flag_mismatch(input string what, input bin_result_t want,
                                 input bin_result_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("%0t %s: want value %0d count %0d status %0d, got %0d %0d %0d",
                     $time, what, want.value, want.count, want.status,
                     got.value, got.count, got.status);
    endtask

    // ------------------------------------------------------------------
    // Result side: ready pattern and checking
    // ------------------------------------------------------------------

    // Drive ready from the falling edge. A hold request stalls the result channel for a
    // long stretch so the block backs up into the item channel.
    initial
    begin : result_drain
        int stall_left;
        stall_left      = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            if (quiet_phase)
            begin
                stall_left = 0;
                result_ch.ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < 20)
            begin
                stall_left = pick_gap() - 1;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Compare each accepted result beat with the oldest owed result
    initial
    begin : result_check
        bin_result_t got;
        bin_result_t want;
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
            begin
                got.value  = result_ch.bin_value;
                got.count  = result_ch.bin_count;
                got.status = result_ch.status;
                if (bin_reports_due.size() == 0)
                begin
                    flag_mismatch("result beat with nothing owed", '0, got);
                end
                else
                begin
                    want = bin_reports_due.pop_front();
                    if (got.value !== want.value || got.count !== want.count ||
                        got.status !== want.status)
                        flag_mismatch("result beat differs", want, got);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial
    begin : stimulus
        dir_row_t dir_tab [DIR_N];
        int       sent;
        int       phase;
        int       phase_len;

        rst_n               = 1'b0;
        quiet_phase         = 1'b0;
        hold_req            = 1'b0;
        item_ch.valid       = 1'b0;
        item_ch.kind        = KIND_CLEAR;
        item_ch.pixel_row   = '0;
        item_ch.pixel_col   = '0;
        item_ch.pixel_value = '0;
        item_ch.bin_index   = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = CFG_ANGLE_P;
        cfg_ch.data         = '0;

        // Register values after reset: p 1, q 0, a 64 by 64 image, so 64 bins
        shadow_p    = 4'd1;
        shadow_q    = 5'sd0;
        shadow_rows = 7'd64;
        shadow_cols = 7'd64;
        foreach (bin_mirror[i])
            bin_mirror[i] = '0;

        dir_tab = '{
            // Fresh from reset: empty bins, edges of the bin range
            pinned_to(read_beat(0),          0, 64, STATUS_OK),
            pinned_to(read_beat(64),         0, 64, STATUS_RANGE),
            pinned_to(read_beat(2047),       0, 64, STATUS_RANGE),
            // Corner pixels land in the last and the first bin
            pinned_to(pixel_beat(0, 0, 255),   0, 64, STATUS_OK),
            pinned_to(pixel_beat(63, 63, 255), 0, 64, STATUS_OK),
            pixel_beat(63, 0, 1),
            pinned_to(read_beat(63),         255, 64, STATUS_OK),
            pinned_to(read_beat(0),          256, 64, STATUS_OK),
            pinned_to(bare_beat(KIND_SPARE), 0, 64, STATUS_OK),
            pinned_to(bare_beat(KIND_CLEAR), 0, 64, STATUS_OK),
            pinned_to(read_beat(63),         0, 64, STATUS_OK),
            // Steepest slopes of the same sign: the widest projection
            reg_write(CFG_ANGLE_P, 15),
            reg_write(CFG_ANGLE_Q, 15),
            pinned_to(pixel_beat(0, 63, 255), 0, 1891, STATUS_OK),
            pinned_to(read_beat(1890),       255, 1891, STATUS_OK),
            pinned_to(read_beat(1891),       0, 1891, STATUS_RANGE),
            // Opposite signs, then a q code that has to be clamped
            reg_write(CFG_ANGLE_Q, 17),
            pixel_beat(63, 63, 255),
            read_beat(1890),
            reg_write(CFG_ANGLE_Q, 16),
            pixel_beat(0, 0, 7),
            // Zero p with negative q: any column past zero gives a negative bin
            reg_write(CFG_ANGLE_P, 0),
            reg_write(CFG_ANGLE_Q, 31),
            pinned_to(pixel_beat(0, 1, 9),   0, 64, STATUS_RANGE),
            pinned_to(pixel_beat(5, 0, 9),   0, 64, STATUS_OK),
            // Small image: coordinates just outside it
            reg_write(CFG_ANGLE_P, 1),
            reg_write(CFG_ANGLE_Q, 2),
            reg_write(CFG_NUM_ROWS, 4),
            reg_write(CFG_NUM_COLS, 4),
            pinned_to(pixel_beat(4, 0, 1),   0, 10, STATUS_RANGE),
            pinned_to(pixel_beat(0, 4, 1),   0, 10, STATUS_RANGE),
            pixel_beat(3, 3, 200),
            read_beat(6),
            // Sizes below and above the legal range get clamped
            reg_write(CFG_NUM_ROWS, 0),
            reg_write(CFG_NUM_COLS, 127),
            pixel_beat(0, 63, 255),
            read_beat(126)
        };

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Walk the directed table; hold register writes until the block is idle
        foreach (dir_tab[i])
        begin
            if (dir_tab[i].is_cfg)
            begin
                wait_idle();
                write_reg(dir_tab[i].cfg_sel, dir_tab[i].cfg_data);
            end
            else
            begin
                send_beat(dir_tab[i].beat, dir_tab[i].pinned, dir_tab[i].pin);
            end
        end

        // Random phases: fresh registers each time, some phases with no idling, and one
        // with a long stall on the result side while items keep coming
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            wait_idle();
            random_setup();
            quiet_phase = ($urandom_range(0, 4) == 0);
            if (phase == 2)
                hold_req = 1'b1;
            phase_len = $urandom_range(40, 160);
            if (phase_len > RANDOM_ITEMS - sent)
                phase_len = RANDOM_ITEMS - sent;
            repeat (phase_len)
            begin
                send_beat(random_beat(), 1'b0, '0);
                sent++;
            end
            phase++;
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("mojette_projection_accumulator_unit: match");
        else
            $display("mojette_projection_accumulator_unit: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
design/mpa_pkg.sv
design/mpa_if.sv
design/mpa_ram.sv
design/mpa_datapath.sv
design/mpa_ctrl.sv
design/mojette_projection_accumulator_unit.sv
sim/tb_mojette_projection_accumulator_unit.sv
